// File: rtl/base32_validating_decoder_assert.svh
// ----------------------------------------------------------------------------
// Base32 decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BASE32_VALIDATING_DECODER_ASSERT_SVH
`define BASE32_VALIDATING_DECODER_ASSERT_SVH

// same-cycle implication
`define B32D_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b32d assertion failed");

// next-cycle implication
`define B32D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b32d assertion failed");

`endif

// File: rtl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// Base32 decoder package
// Payload types, status codes and shared constants
// ----------------------------------------------------------------------------
package b32d_pkg;

	// default bound on characters per text
	localparam int MAX_CHARS_DEF = 256;

	// status codes reported on the last character
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_CHAR = 3'd1,
		ST_BAD_PAD  = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	// one input character
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	// one result
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic       end_of_key;
		logic [2:0] status;
		logic [7:0] key_length;
	} out_item_t;

	// character class
	typedef struct packed {
		logic       is_sym;
		logic       is_pad;
		logic [4:0] sym;
	} char_class_t;

endpackage

// File: rtl/b32d_chan_if.sv
// ----------------------------------------------------------------------------
// Base32 decoder channel
// Valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface b32d_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/b32d_classify.sv
// ----------------------------------------------------------------------------
// Base32 character classifier
// Maps an ASCII code to a 5-bit symbol, a padding mark or neither
// ----------------------------------------------------------------------------
module b32d_classify import b32d_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	// A-Z give 0..25, 2-7 give 26..31, '=' is padding
	always_comb begin
		cls = '0;
		if (char_code >= 8'h41 && char_code <= 8'h5A) begin
			cls.is_sym = 1'b1;
			cls.sym    = 5'(char_code - 8'h41);
		end else if (char_code >= 8'h32 && char_code <= 8'h37) begin
			cls.is_sym = 1'b1;
			cls.sym    = 5'(char_code - 8'h32 + 8'd26);
		end else if (char_code == 8'h3D) begin
			cls.is_pad = 1'b1;
		end
	end

endmodule

// File: rtl/b32d_core.sv
// ----------------------------------------------------------------------------
// Base32 decoder core
// Per-text state, validation and bit packing for one character per step
// ----------------------------------------------------------------------------
module b32d_core import b32d_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t result,
	output logic      has_result
);

	`include "base32_validating_decoder_assert.svh"

	localparam int CntW = $clog2(MAX_CHARS + 2);
	localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHARS);

	logic [2:0]      pos_q;
	logic [6:0]      buf_q;
	logic [2:0]      bits_q;
	logic [CntW-1:0] chars_q;
	logic [7:0]      bytes_q;
	logic            pad_q;
	status_t         err_q;

	logic [2:0]      pos_nx;
	logic [6:0]      buf_nx;
	logic [2:0]      bits_nx;
	logic [CntW-1:0] chars_nx;
	logic [7:0]      bytes_nx;
	logic            pad_nx;
	status_t         err_nx;

	char_class_t     cls;
	logic            have_byte;
	logic [7:0]      byte_val;
	logic [11:0]     wide;
	logic [3:0]      sum;
	logic [2:0]      rem;

	function automatic status_t keep_first(input status_t cur, input status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	b32d_classify u_classify (
		.char_code(item.char_code),
		.cls      (cls)
	);

	// character count saturates one past the limit
	assign chars_nx = (chars_q <= MaxCnt) ? chars_q + 1'b1 : chars_q;
	assign pos_nx   = pos_q + 3'd1;

	// validation and bit packing
	always_comb begin
		err_nx    = err_q;
		pad_nx    = pad_q;
		buf_nx    = buf_q;
		bits_nx   = bits_q;
		bytes_nx  = bytes_q;
		have_byte = 1'b0;
		byte_val  = '0;
		wide      = {buf_q, 5'd0};
		sum       = {1'b0, bits_q} + 4'd5;
		rem       = '0;
		if (chars_nx > MaxCnt) begin
			err_nx = keep_first(err_nx, ST_TOO_LONG);
		end
		if (!cls.is_sym && !cls.is_pad) begin
			err_nx = keep_first(err_nx, ST_BAD_CHAR);
		end else if (pad_q) begin
			if (!cls.is_pad || pos_q == 3'd0) err_nx = keep_first(err_nx, ST_BAD_PAD);
		end else if (cls.is_pad) begin
			pad_nx = 1'b1;
			if (!(pos_q == 3'd2 || pos_q == 3'd4 || pos_q == 3'd5 || pos_q == 3'd7)) begin
				err_nx = keep_first(err_nx, ST_BAD_PAD);
			end
		end else if (err_nx == ST_OK) begin
			wide = {buf_q, cls.sym};
			if (sum >= 4'd8) begin
				rem       = 3'(sum - 4'd8);
				byte_val  = 8'(wide >> rem);
				buf_nx    = 7'(wide & ((12'd1 << rem) - 12'd1));
				bits_nx   = rem;
				bytes_nx  = bytes_q + 8'd1;
				have_byte = 1'b1;
			end else begin
				buf_nx  = wide[6:0];
				bits_nx = sum[2:0];
			end
		end
		if (item.last_char && pos_nx != 3'd0) begin
			err_nx = keep_first(err_nx, ST_BAD_LEN);
		end
	end

	// result fields
	always_comb begin
		result.byte_valid = have_byte;
		result.data_byte  = byte_val;
		result.byte_index = have_byte ? bytes_q : 8'd0;
		result.end_of_key = item.last_char;
		result.status     = item.last_char ? err_nx : ST_OK;
		result.key_length = (item.last_char && err_nx == ST_OK) ? bytes_nx : 8'd0;
	end

	assign has_result = have_byte || item.last_char;

	// state registers, cleared after the last character of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			buf_q   <= '0;
			bits_q  <= '0;
			chars_q <= '0;
			bytes_q <= '0;
			pad_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (step) begin
			if (item.last_char) begin
				pos_q   <= '0;
				buf_q   <= '0;
				bits_q  <= '0;
				chars_q <= '0;
				bytes_q <= '0;
				pad_q   <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				pos_q   <= pos_nx;
				buf_q   <= buf_nx;
				bits_q  <= bits_nx;
				chars_q <= chars_nx;
				bytes_q <= bytes_nx;
				pad_q   <= pad_nx;
				err_q   <= err_nx;
			end
		end
	end

	`B32D_ASSERT_NOW(a_no_byte_after_error, step && result.byte_valid, err_q == ST_OK)
	`B32D_ASSERT_NOW(a_buffer_in_range, 1'b1, (buf_q >> bits_q) == 7'd0)
	`B32D_ASSERT_NEXT(a_clear_after_last, step && item.last_char,
		pos_q == 3'd0 && bytes_q == 8'd0 && chars_q == '0 && err_q == ST_OK)

endmodule

// File: rtl/base32_validating_decoder.sv
// ----------------------------------------------------------------------------
// Base32 validating decoder
// Decodes base32 text, one character per transfer, into key bytes
// ----------------------------------------------------------------------------
// in_ch carries one character (char_code, last_char) per transfer; out_ch
// carries results: a decoded byte with its index, and on the last character
// of a text end_of_key with status and key_length. A character that neither
// completes a byte nor ends the text gives no result.
// A character taken from in_ch goes into the input register, is worked by
// the core into the result register when the core steps, and shows on out_ch
// from there. Throughput: one character per cycle while out_ch is ready;
// the core updates its text state within each step, which sets that figure.
// Reset clears all text state and the valid flags of both registers; the
// first character after reset starts a new text. After the last character
// the state returns to that reset state for the next text.
// When out_ch stalls, a pending result stays in the result register, and
// characters that give no result still flow; the input register fills and
// in_ch.ready drops only when a result cannot move forward.
// ----------------------------------------------------------------------------
module base32_validating_decoder import b32d_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	b32d_chan_if.sink   in_ch,
	b32d_chan_if.source out_ch
);

	`include "base32_validating_decoder_assert.svh"

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;

	out_item_t result;
	logic      has_result;
	logic      out_free;
	logic      step;
	logic      in_xfer;

	b32d_core #(
		.MAX_CHARS(MAX_CHARS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.result    (result),
		.has_result(has_result)
	);

	// handshake control
	assign out_free     = !valid_s2 || out_ch.ready;
	assign step         = valid_s1 && (!has_result || out_free);
	assign in_ch.ready  = !valid_s1 || step;
	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) item_s1 <= in_ch.data;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) res_s2 <= result;
	end

	`B32D_ASSERT_NEXT(a_take_fills_s1, in_xfer, valid_s1)
	`B32D_ASSERT_NEXT(a_result_lands, step && has_result,
		valid_s2 && res_s2.end_of_key == $past(item_s1.last_char))
	`B32D_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data))

endmodule
